[src/qlti_pkg.sv]
// Shared types and constants of the quadrilinear table interpolation core.
// Used by the front end, the back end, the divider and the top level. No dependencies.
package qlti_pkg;

  localparam int AXES     = 4;
  localparam int COORD_W  = 32;
  localparam int SIZE_W   = 4;
  localparam int FRAC_W   = 16;
  localparam int CORNERS  = 16;

  localparam logic [FRAC_W:0]   ONE_Q16    = 17'h10000;
  localparam logic [FRAC_W-1:0] HALF_Q16   = 16'h8000;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd2;

  typedef enum logic [1:0] {
    OP_QUERY    = 2'd0,
    OP_BP_WRITE = 2'd1,
    OP_TB_WRITE = 2'd2,
    OP_UNUSED   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CMD_QUERY,
    CMD_BP_WRITE,
    CMD_TB_WRITE
  } cmd_kind_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [AXES-1:0] coord_vec_t;
  typedef logic [AXES-1:0][SIZE_W-1:0] size_vec_t;

endpackage

[src/qlti_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qlti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/qlti_div.sv]
// Restoring divider for the axis fraction, one quotient bit per cycle.
// Depends on qlti_pkg. Requires num < den on start.
module qlti_div
  import qlti_pkg::*;
#(
  parameter int XW = 33
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [XW-1:0]     num,
  input  logic [XW-1:0]     den,
  output logic              done,
  output logic [FRAC_W-1:0] quo
);

  logic [XW:0]           rem_r;
  logic [XW-1:0]         den_r;
  logic [FRAC_W-1:0]     quo_r;
  logic [4:0]            cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [XW:0]           shl;
  logic                  fits;

  assign shl  = {rem_r[XW-1:0], 1'b0};
  assign fits = shl >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rem_r  <= {1'b0, num};
        den_r  <= den;
        cnt_r  <= 5'(FRAC_W);
      end else if (busy_r) begin
        // shift in one quotient bit
        rem_r <= fits ? shl - {1'b0, den_r} : shl;
        quo_r <= {quo_r[FRAC_W-2:0], fits};
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

[src/qlti_front.sv]
// Front end: accept input transactions, classify and saturate them, and queue
// them for the back end. Depends on qlti_pkg.
module qlti_front
  import qlti_pkg::*;
#(
  parameter int MAX_POINTS    = 8,
  parameter int TABLE_ENTRIES = 4096,
  parameter int VALUE_WIDTH   = 32,
  parameter int BPA           = 5,
  parameter int TW            = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [1:0]                    in_operation,
  input  logic [1:0]                    in_axis,
  input  logic [2:0]                    in_point_index,
  input  logic [11:0]                   in_table_address,
  input  logic signed [31:0]            in_write_value,
  input  coord_vec_t                    in_coord,
  output logic                          q_valid,
  input  logic                          q_pop,
  output cmd_kind_t                     q_kind,
  output logic [BPA-1:0]                q_bp_addr,
  output logic [TW-1:0]                 q_tb_addr,
  output logic signed [VALUE_WIDTH-1:0] q_value,
  output coord_vec_t                    q_coord
);

  localparam int VW = VALUE_WIDTH;
  localparam int CW = (VW > 32) ? VW : 32;
  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  logic                 keep;
  cmd_kind_t            kind;
  logic signed [CW-1:0] wv_ext;
  logic signed [VW-1:0] wv_sat;
  logic                 enq;

  cmd_kind_t            kind_q  [2];
  logic [BPA-1:0]       bp_q    [2];
  logic [TW-1:0]        tb_q    [2];
  logic signed [VW-1:0] val_q   [2];
  coord_vec_t           coord_q [2];
  logic [1:0]           count_r;
  logic                 wp_r;
  logic                 rp_r;

  always_comb begin
    keep = 1'b0;
    kind = CMD_QUERY;
    case (in_operation)
      OP_QUERY: begin
        keep = 1'b1;
      end
      OP_BP_WRITE: begin
        kind = CMD_BP_WRITE;
        keep = {29'd0, in_point_index} < 32'(MAX_POINTS);
      end
      OP_TB_WRITE: begin
        kind = CMD_TB_WRITE;
        keep = {20'd0, in_table_address} < 32'(TABLE_ENTRIES);
      end
      default: keep = 1'b0;
    endcase
  end

  // Saturate the write value to the stored width
  always_comb begin
    wv_ext = CW'(in_write_value);
    if (wv_ext > CW'(VMAX)) begin
      wv_sat = VMAX;
    end else if (wv_ext < CW'(VMIN)) begin
      wv_sat = VMIN;
    end else begin
      wv_sat = wv_ext[VW-1:0];
    end
  end

  assign in_full = (count_r == 2'd2);
  assign enq     = in_push && !in_full && keep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
    end else begin
      if (enq) begin
        kind_q[wp_r]  <= kind;
        bp_q[wp_r]    <= BPA'(32'(in_axis) * 32'(MAX_POINTS) + 32'(in_point_index));
        tb_q[wp_r]    <= TW'(in_table_address);
        val_q[wp_r]   <= wv_sat;
        coord_q[wp_r] <= in_coord;
        wp_r          <= !wp_r;
      end
      if (q_pop) begin
        rp_r <= !rp_r;
      end
      count_r <= count_r + 2'(enq) - 2'(q_pop);
    end
  end

  assign q_valid   = (count_r != 2'd0);
  assign q_kind    = kind_q[rp_r];
  assign q_bp_addr = bp_q[rp_r];
  assign q_tb_addr = tb_q[rp_r];
  assign q_value   = val_q[rp_r];
  assign q_coord   = coord_q[rp_r];

endmodule

[src/qlti_back.sv]
// Back end: execute queued writes and queries (search, fraction, corner reads,
// lerp reduction) and hold the result. Depends on qlti_pkg, qlti_ram, qlti_div.
module qlti_back
  import qlti_pkg::*;
#(
  parameter int MAX_POINTS    = 8,
  parameter int TABLE_ENTRIES = 4096,
  parameter int VALUE_WIDTH   = 32,
  parameter int BPA           = 5,
  parameter int TW            = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  size_vec_t                     cfg_size,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  cmd_kind_t                     q_kind,
  input  logic [BPA-1:0]                q_bp_addr,
  input  logic [TW-1:0]                 q_tb_addr,
  input  logic signed [VALUE_WIDTH-1:0] q_value,
  input  coord_vec_t                    q_coord,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic signed [31:0]            out_interp_value
);

  localparam int VW  = VALUE_WIDTH;
  localparam int CW  = (VW > 32) ? VW : 32;
  localparam int XW  = CW + 1;
  localparam int NW  = $clog2(MAX_POINTS + 1);
  localparam int IW  = $clog2(MAX_POINTS);
  localparam int QAW = $clog2(MAX_POINTS ** 4);
  localparam int CAW = (QAW > TW + 1) ? QAW : TW + 1;
  localparam int PW  = VW + 19;
  localparam logic signed [CW-1:0] OMAX = CW'(33'sh0_7FFF_FFFF);
  localparam logic signed [CW-1:0] OMIN = CW'(33'sh1_8000_0000);

  typedef enum logic [3:0] {
    S_IDLE, S_AX_RD, S_AX_CHK, S_FRAC, S_DIV, S_STR1, S_STR2,
    S_BASE1, S_BASE2, S_C_RD, S_C_DAT, S_RED, S_ADD, S_OUT
  } state_t;

  state_t                state_r;
  coord_vec_t            coord_r;
  logic [1:0]            ax_r;
  logic [IW-1:0]         k_r;
  logic [IW-1:0]         i_r;
  logic                  upd_r;
  logic signed [XW-1:0]  x0_r, xi_r, xi1_r, xl_r;
  logic [IW-1:0]         idx_r [AXES];
  logic [FRAC_W:0]       fr_r  [AXES];
  logic [QAW-1:0]        s2_r, s3_r, t12_r, m3_r, m4_r, base_r;
  logic [3:0]            p_r;
  logic                  oob_r;
  logic signed [VW-1:0]  hold_r [AXES];
  logic [AXES-1:0]       hv_r;
  logic [2:0]            lvl_r;
  logic signed [VW-1:0]  val_r;
  logic signed [PW-1:0]  prod_r;
  logic signed [31:0]    out_r;
  logic                  ov_r;

  logic [NW-1:0]         eff [AXES];
  logic [VW-1:0]         bp_rdata, tb_rdata;
  logic [BPA-1:0]        bp_raddr;
  logic [CAW-1:0]        caddr;
  logic signed [XW-1:0]  x_cur, c_cur, num, den;
  logic                  div_start, div_done;
  logic [FRAC_W-1:0]     div_quo;
  logic signed [VW:0]    diff;
  logic signed [PW-1:0]  rsum;
  logic signed [VW+1:0]  lres;
  logic signed [CW-1:0]  vext;
  logic signed [31:0]    vsat;
  logic                  bp_we, tb_we;

  // Clamp each axis size to 2..MAX_POINTS
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      if (cfg_size[a] < SIZE_W'(2)) begin
        eff[a] = NW'(2);
      end else if (32'(cfg_size[a]) > 32'(MAX_POINTS)) begin
        eff[a] = NW'(MAX_POINTS);
      end else begin
        eff[a] = NW'(cfg_size[a]);
      end
    end
  end

  assign q_pop = (state_r == S_IDLE) && q_valid;
  assign bp_we = q_pop && (q_kind == CMD_BP_WRITE);
  assign tb_we = q_pop && (q_kind == CMD_TB_WRITE);

  assign bp_raddr = BPA'(32'(ax_r) * 32'(MAX_POINTS) + 32'(k_r));

  // Corner order: step bit1 -> axis 2, bit0 -> axis 1, bit2 -> axis 3, bit3 -> axis 4
  assign caddr = CAW'(base_r) + CAW'(p_r[1])
               + (p_r[0] ? CAW'(eff[1]) : '0)
               + (p_r[2] ? CAW'(s2_r) : '0)
               + (p_r[3] ? CAW'(s3_r) : '0);

  qlti_ram #(.WIDTH(VW), .DEPTH(AXES * MAX_POINTS)) u_bp_ram (
    .clk   (clk),
    .we    (bp_we),
    .waddr (q_bp_addr),
    .wdata (q_value),
    .raddr (bp_raddr),
    .rdata (bp_rdata)
  );

  qlti_ram #(.WIDTH(VW), .DEPTH(TABLE_ENTRIES)) u_tb_ram (
    .clk   (clk),
    .we    (tb_we),
    .waddr (q_tb_addr),
    .wdata (q_value),
    .raddr (TW'(caddr)),
    .rdata (tb_rdata)
  );

  assign x_cur = XW'($signed(bp_rdata));
  assign c_cur = XW'($signed(coord_r[ax_r]));
  assign num   = c_cur - xi_r;
  assign den   = xi1_r - xi_r;

  assign div_start = (state_r == S_FRAC) && !(c_cur < x0_r) && !(c_cur >= xl_r)
                     && (den > 0) && (num >= 0) && (num < den);

  qlti_div #(.XW(XW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign diff = (VW+1)'(val_r) - (VW+1)'(hold_r[lvl_r[1:0]]);
  assign rsum = prod_r + PW'(HALF_Q16);
  assign lres = (VW+2)'(rsum >>> FRAC_W) + (VW+2)'(hold_r[lvl_r[1:0]]);

  always_comb begin
    vext = CW'(val_r);
    if (vext > OMAX) begin
      vsat = 32'sh7FFF_FFFF;
    end else if (vext < OMIN) begin
      vsat = 32'sh8000_0000;
    end else begin
      vsat = vext[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      hv_r    <= '0;
      upd_r   <= 1'b0;
    end else begin
      // S_OUT decides the result register on its own
      if (out_pop && ov_r && state_r != S_OUT) begin
        ov_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid && q_kind == CMD_QUERY) begin
            coord_r <= q_coord;
            ax_r    <= '0;
            k_r     <= '0;
            state_r <= S_AX_RD;
          end
        end
        S_AX_RD: state_r <= S_AX_CHK;
        S_AX_CHK: begin
          if (k_r == '0) begin
            x0_r  <= x_cur;
            xi_r  <= x_cur;
            i_r   <= '0;
            upd_r <= 1'b1;
          end else begin
            if (upd_r) begin
              xi1_r <= x_cur;
            end
            upd_r <= (32'(k_r) + 32'd2 <= 32'(eff[ax_r])) && (x_cur <= c_cur);
            if ((32'(k_r) + 32'd2 <= 32'(eff[ax_r])) && (x_cur <= c_cur)) begin
              i_r   <= k_r;
              xi_r  <= x_cur;
            end
          end
          if (32'(k_r) + 32'd1 == 32'(eff[ax_r])) begin
            xl_r    <= x_cur;
            state_r <= S_FRAC;
          end else begin
            k_r     <= k_r + IW'(1);
            state_r <= S_AX_RD;
          end
        end
        S_FRAC: begin
          if (c_cur < x0_r) begin
            idx_r[ax_r] <= i_r;
            fr_r[ax_r]  <= '0;
          end else if (c_cur >= xl_r) begin
            idx_r[ax_r] <= IW'(eff[ax_r] - NW'(2));
            fr_r[ax_r]  <= ONE_Q16;
          end else if (den <= 0 || num < 0) begin
            idx_r[ax_r] <= i_r;
            fr_r[ax_r]  <= '0;
          end else if (num >= den) begin
            idx_r[ax_r] <= i_r;
            fr_r[ax_r]  <= ONE_Q16;
          end else begin
            idx_r[ax_r] <= i_r;
          end
          if (div_start) begin
            state_r <= S_DIV;
          end else if (ax_r == 2'(AXES - 1)) begin
            state_r <= S_STR1;
          end else begin
            ax_r    <= ax_r + 2'd1;
            k_r     <= '0;
            state_r <= S_AX_RD;
          end
        end
        S_DIV: begin
          if (div_done) begin
            fr_r[ax_r] <= {1'b0, div_quo};
            if (ax_r == 2'(AXES - 1)) begin
              state_r <= S_STR1;
            end else begin
              ax_r    <= ax_r + 2'd1;
              k_r     <= '0;
              state_r <= S_AX_RD;
            end
          end
        end
        S_STR1: begin
          s2_r    <= QAW'(eff[0]) * QAW'(eff[1]);
          t12_r   <= QAW'(idx_r[0]) * QAW'(eff[1]) + QAW'(idx_r[1]);
          state_r <= S_STR2;
        end
        S_STR2: begin
          s3_r    <= s2_r * QAW'(eff[2]);
          m3_r    <= QAW'(idx_r[2]) * s2_r;
          state_r <= S_BASE1;
        end
        S_BASE1: begin
          m4_r    <= QAW'(idx_r[3]) * s3_r;
          state_r <= S_BASE2;
        end
        S_BASE2: begin
          base_r  <= m4_r + m3_r + t12_r;
          p_r     <= '0;
          hv_r    <= '0;
          state_r <= S_C_RD;
        end
        S_C_RD: begin
          oob_r   <= caddr >= CAW'(TABLE_ENTRIES);
          state_r <= S_C_DAT;
        end
        S_C_DAT: begin
          val_r   <= oob_r ? '0 : $signed(tb_rdata);
          lvl_r   <= '0;
          state_r <= S_RED;
        end
        S_RED: begin
          // Walk the partial-result stack: park, or combine with the held value
          if (lvl_r == 3'(AXES)) begin
            state_r <= S_OUT;
          end else if (!hv_r[lvl_r[1:0]]) begin
            hold_r[lvl_r[1:0]] <= val_r;
            hv_r[lvl_r[1:0]]   <= 1'b1;
            p_r                <= p_r + 4'd1;
            state_r            <= S_C_RD;
          end else begin
            prod_r  <= $signed({1'b0, fr_r[lvl_r[1:0]]}) * diff;
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          val_r            <= lres[VW-1:0];
          hv_r[lvl_r[1:0]] <= 1'b0;
          lvl_r            <= lvl_r + 3'd1;
          state_r          <= S_RED;
        end
        S_OUT: begin
          if (!ov_r || out_pop) begin
            out_r   <= vsat;
            ov_r    <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_empty        = !ov_r;
  assign out_interp_value = out_r;

endmodule

[src/quadrilinear_table_interp_core.sv]
// Top level of the four-dimensional table interpolation core.
// Depends on qlti_pkg, qlti_front, qlti_back (and through it qlti_ram, qlti_div).
//
// Usage:
//   Input channel (push/full): each transaction is a query, a breakpoint write
//   or a table write. Writes give no result; breakpoint writes beyond the axis
//   depth, table writes beyond the table and unused opcodes are dropped.
//   Result channel (empty/pop): one interpolated Q16.16 value per query, in
//   query order, held on out_interp_value while empty is low.
//   Config channel (valid/ready, always ready): four axis sizes. The user must
//   write them only while the core is idle; the core does not enforce this.
// Operation:
//   A write is performed as the idle back end pops it. A query runs the
//   per-axis search and fraction, the bit-serial divider for each axis that
//   needs a fraction, then 16 corner reads and 15 lerps on one shared multiplier.
//   A two-entry queue lets the front accept while the back is busy.
// Reset: axis sizes return to 2, queues and the result register empty.
//   Breakpoint and table memories hold their contents until written.
// Stall: a finished result waits in the output register; the back end holds
//   its next result until it is popped, and the front queues until it is full.
module quadrilinear_table_interp_core
  import qlti_pkg::*;
#(
  parameter int MAX_POINTS    = 8,
  parameter int TABLE_ENTRIES = 4096,
  parameter int VALUE_WIDTH   = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_operation,
  input  logic [1:0]         in_axis,
  input  logic [2:0]         in_point_index,
  input  logic [11:0]        in_table_address,
  input  logic signed [31:0] in_write_value,
  input  logic signed [31:0] in_coord1,
  input  logic signed [31:0] in_coord2,
  input  logic signed [31:0] in_coord3,
  input  logic signed [31:0] in_coord4,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_interp_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [3:0]         cfg_data
);

  localparam int BPA = $clog2(AXES * MAX_POINTS);
  localparam int TW  = $clog2(TABLE_ENTRIES);

  size_vec_t                     size_r;
  coord_vec_t                    in_coord;
  logic                          q_valid;
  logic                          q_pop;
  cmd_kind_t                     q_kind;
  logic [BPA-1:0]                q_bp_addr;
  logic [TW-1:0]                 q_tb_addr;
  logic signed [VALUE_WIDTH-1:0] q_value;
  coord_vec_t                    q_coord;

  // Config registers: take every write, index selects the axis
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < AXES; a++) begin
        size_r[a] <= SIZE_RESET;
      end
    end else if (cfg_valid && cfg_ready) begin
      size_r[cfg_index] <= cfg_data;
    end
  end

  assign in_coord = {in_coord4, in_coord3, in_coord2, in_coord1};

  qlti_front #(
    .MAX_POINTS    (MAX_POINTS),
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .VALUE_WIDTH   (VALUE_WIDTH),
    .BPA           (BPA),
    .TW            (TW)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_operation     (in_operation),
    .in_axis          (in_axis),
    .in_point_index   (in_point_index),
    .in_table_address (in_table_address),
    .in_write_value   (in_write_value),
    .in_coord         (in_coord),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .q_kind           (q_kind),
    .q_bp_addr        (q_bp_addr),
    .q_tb_addr        (q_tb_addr),
    .q_value          (q_value),
    .q_coord          (q_coord)
  );

  qlti_back #(
    .MAX_POINTS    (MAX_POINTS),
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .VALUE_WIDTH   (VALUE_WIDTH),
    .BPA           (BPA),
    .TW            (TW)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_size         (size_r),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .q_kind           (q_kind),
    .q_bp_addr        (q_bp_addr),
    .q_tb_addr        (q_tb_addr),
    .q_value          (q_value),
    .q_coord          (q_coord),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_interp_value (out_interp_value)
  );

endmodule

[src/qlti_core_chk.sv]
// Port-level checker for the interpolation core, bound to the top level.
// No package dependencies.
module qlti_core_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_push,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic [31:0] out_interp_value
);

  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result channel not empty after reset");

  a_not_full_after_reset: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input channel full after reset");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_interp_value)))
    else $error("waiting result changed or vanished");

  a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> $past(in_push))
    else $error("input queue filled without a transaction");

endmodule

bind quadrilinear_table_interp_core qlti_core_chk u_chk (.*);

[tb/quadrilinear_table_interp_core_tb.sv]
// Self-checking testbench for quadrilinear_table_interp_core: directed table, then random phases.
// Depends on qlti_pkg and the core; holds its own Q16.16 interpolation predictor.
module quadrilinear_table_interp_core_tb;
  import qlti_pkg::*;

  localparam int NPTS      = 8;
  localparam int NENTRIES  = 4096;
  localparam int TBL_USED  = 256;  // table cells that the axis sizes may reach
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE    = 300;
  localparam logic [1:0] REG_SIZE_AXIS1 = 2'd0;

  typedef struct {
    op_t              op;
    logic [1:0]       ax;
    logic [2:0]       pt;
    logic [11:0]      addr;
    logic signed [31:0] wv;
    logic signed [31:0] c [4];
    bit               typed;
    logic signed [31:0] tv;
  } txn_t;

  logic clk, rst_n;
  logic in_push, in_full;
  logic [1:0] in_operation, in_axis;
  logic [2:0] in_point_index;
  logic [11:0] in_table_address;
  logic signed [31:0] in_write_value, in_coord1, in_coord2, in_coord3, in_coord4;
  logic out_empty, out_pop;
  logic signed [31:0] out_interp_value;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [3:0] cfg_data;

  quadrilinear_table_interp_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_operation(in_operation), .in_axis(in_axis), .in_point_index(in_point_index),
    .in_table_address(in_table_address), .in_write_value(in_write_value),
    .in_coord1(in_coord1), .in_coord2(in_coord2), .in_coord3(in_coord3),
    .in_coord4(in_coord4),
    .out_empty(out_empty), .out_pop(out_pop), .out_interp_value(out_interp_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow state of the core: axis sizes, breakpoints and table values.
  logic [3:0] axis_size [4];
  longint     bp_mem [4*NPTS];
  longint     tbl_mem [NENTRIES];

  longint     interp_expected [$];
  int         fail_count;
  int         tx_idle_pct, rx_idle_pct;
  int         rx_hold_left;
  int         spread;  // largest breakpoint step of the current phase; 0 selects wide fixed steps

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int clamp_size(int s);
    int n;
    n = s;
    if (n < 2) n = 2;
    if (n > NPTS) n = NPTS;
    return n;
  endfunction

  function automatic int eff_size(int a);
    return clamp_size(int'(axis_size[a]));
  endfunction

  // Find the enclosing interval on one axis and the Q1.16 fraction within it.
  function automatic void locate_axis(int a, longint c, output int idx, output longint fr);
    int n, base;
    longint den, num;
    n = eff_size(a);
    base = a * NPTS;
    idx = 0;
    for (int k = 0; k < n - 1; k++)
      if (bp_mem[base+k] <= c) idx = k;
    if (c < bp_mem[base]) begin
      fr = 0;
    end else if (c >= bp_mem[base+n-1]) begin
      idx = n - 2;
      fr = 65536;
    end else begin
      den = bp_mem[base+idx+1] - bp_mem[base+idx];
      num = c - bp_mem[base+idx];
      if (den <= 0 || num < 0) fr = 0;
      else begin
        num = (num <<< 16) / den;
        fr = (num > 65536) ? 64'sd65536 : num;
      end
    end
  endfunction

  function automatic longint lerp_q16(longint a, longint b, longint f);
    return a + ((f * (b - a) + 32768) >>> 16);
  endfunction

  function automatic longint predict_interp(txn_t t);
    int idx [4];
    longint fr [4];
    longint v [16];
    longint r1 [8];
    longint r2 [4];
    longint r3 [2];
    longint r;
    int n1, n2, n3, i1, i2, i3, i4, adr, lo;
    n1 = eff_size(0);
    n2 = eff_size(1);
    n3 = eff_size(2);
    for (int a = 0; a < 4; a++) locate_axis(a, longint'(t.c[a]), idx[a], fr[a]);
    // corner bit0 walks axis 2, bit1 axis 1, bit2 axis 3, bit3 axis 4
    for (int k = 0; k < 16; k++) begin
      i2 = idx[1] + (k & 1);
      i1 = idx[0] + ((k >> 1) & 1);
      i3 = idx[2] + ((k >> 2) & 1);
      i4 = idx[3] + ((k >> 3) & 1);
      adr = i4 * (n1 * n2 * n3) + i3 * (n1 * n2) + i1 * n2 + i2;
      v[k] = (adr < NENTRIES) ? tbl_mem[adr] : 0;
    end
    for (int w = 0; w < 8; w++) begin
      lo = ((w >> 1) << 2) | (w & 1);
      r1[w] = lerp_q16(v[lo], v[lo | 2], fr[0]);
    end
    for (int w = 0; w < 4; w++) r2[w] = lerp_q16(r1[2*w], r1[2*w+1], fr[1]);
    for (int w = 0; w < 2; w++) r3[w] = lerp_q16(r2[2*w], r2[2*w+1], fr[2]);
    r = lerp_q16(r3[0], r3[1], fr[3]);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  int idle_cycles;
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("quadrilinear_table_interp_core_tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: pop at random, hold off on request, compare in order.
  // ---------------------------------------------------------------------------
  initial begin
    longint want;
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) begin
        if (interp_expected.size() == 0) begin
          $error("unexpected result transaction, interp_value %0d", out_interp_value);
          fail_count++;
        end else begin
          want = interp_expected.pop_front();
          if (out_interp_value !== want[31:0]) begin
            $error("interp_value: expected %0d, actual %0d", want, out_interp_value);
            fail_count++;
          end
        end
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  task automatic send_txn(txn_t t);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_operation     <= t.op;
    in_axis          <= t.ax;
    in_point_index   <= t.pt;
    in_table_address <= t.addr;
    in_write_value   <= t.wv;
    in_coord1        <= t.c[0];
    in_coord2        <= t.c[1];
    in_coord3        <= t.c[2];
    in_coord4        <= t.c[3];
    in_push          <= 1'b1;
    do @(posedge clk); while (in_full);
    // accepted at this edge: advance the shadow state or queue the expectation
    case (t.op)
      OP_QUERY:    interp_expected.push_back(t.typed ? longint'(t.tv) : predict_interp(t));
      OP_BP_WRITE: bp_mem[t.ax * NPTS + t.pt] = t.wv;
      OP_TB_WRITE: tbl_mem[t.addr] = t.wv;
      default: ;
    endcase
  endtask

  // Wait for every expected result, then let in-flight writes settle.
  task automatic drain_core();
    in_push <= 1'b0;
    while (interp_expected.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_sizes(logic [3:0] s0, logic [3:0] s1, logic [3:0] s2, logic [3:0] s3);
    logic [3:0] s [4];
    s = '{s0, s1, s2, s3};
    for (int i = 0; i < 4; i++) begin
      cfg_index <= REG_SIZE_AXIS1 + 2'(i);
      cfg_data  <= s[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      axis_size[i] = s[i];
    end
    cfg_valid <= 1'b0;
  endtask

  // Random axis sizes whose table footprint stays inside the loaded cells.
  task automatic random_sizes();
    logic [3:0] s [4];
    int prod;
    do begin
      prod = 1;
      for (int i = 0; i < 4; i++) begin
        s[i] = 4'($urandom_range(0, 15));
        prod = prod * clamp_size(int'(s[i]));
      end
    end while (prod > TBL_USED);
    write_sizes(s[0], s[1], s[2], s[3]);
  endtask

  function automatic txn_t mk(op_t op, int ax, int pt, int addr, longint wv,
                              longint c1, longint c2, longint c3, longint c4,
                              bit typed, longint tv);
    txn_t t;
    t.op = op; t.ax = ax[1:0]; t.pt = pt[2:0]; t.addr = addr[11:0]; t.wv = wv[31:0];
    t.c[0] = c1[31:0]; t.c[1] = c2[31:0]; t.c[2] = c3[31:0]; t.c[3] = c4[31:0];
    t.typed = typed; t.tv = tv[31:0];
    return t;
  endfunction

  function automatic txn_t query(longint c1, longint c2, longint c3, longint c4);
    return mk(OP_QUERY, 0, 0, 0, 0, c1, c2, c3, c4, 1'b0, 0);
  endfunction

  // Load one axis with increasing breakpoints; now and then repeat a point.
  task automatic load_axis(int a);
    longint v;
    v = (spread == 0) ? -64'sd2147483648 : longint'($urandom_range(0, 1 << 21)) - (1 << 20);
    for (int k = 0; k < NPTS; k++) begin
      send_txn(mk(OP_BP_WRITE, a, k, 0, v, 0, 0, 0, 0, 1'b0, 0));
      if (spread == 0) v += 613566756;
      else if ($urandom_range(99) >= 4) v += $urandom_range(1, spread);
    end
  endtask

  function automatic longint pick_coord(int a);
    int r;
    longint c;
    r = $urandom_range(99);
    if (r < 10) return longint'(signed'($urandom));
    c = bp_mem[a * NPTS + $urandom_range(0, NPTS - 1)];
    if (r >= 20)
      c += longint'($urandom_range(0, 2 * (spread == 0 ? 32'h4000_0000 : spread)))
           - (spread == 0 ? 64'sd1073741824 : spread);
    if (c > 64'sd2147483647) c = 64'sd2147483647;
    if (c < -64'sd2147483648) c = -64'sd2147483648;
    return c;
  endfunction

  task automatic random_txn();
    int r;
    r = $urandom_range(99);
    if (r < 70)
      send_txn(query(pick_coord(0), pick_coord(1), pick_coord(2), pick_coord(3)));
    else if (r < 85)
      send_txn(mk(OP_TB_WRITE, 0, 0, $urandom_range(0, NENTRIES - 1), signed'($urandom),
                  0, 0, 0, 0, 1'b0, 0));
    else if (r < 93)
      send_txn(mk(OP_BP_WRITE, $urandom_range(0, 3), $urandom_range(0, 7), 0,
                  pick_coord(0), 0, 0, 0, 0, 1'b0, 0));
    else
      send_txn(mk(OP_UNUSED, $urandom_range(0, 3), $urandom_range(0, 7), $urandom,
                  signed'($urandom), signed'($urandom), signed'($urandom),
                  signed'($urandom), signed'($urandom), 1'b0, 0));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  localparam longint ONE  = 65536;
  localparam longint MAXV = 64'sd2147483647;
  localparam longint MINV = -64'sd2147483648;

  txn_t directed [$];

  initial begin
    in_push = 1'b0; in_operation = OP_QUERY; in_axis = '0; in_point_index = '0;
    in_table_address = '0; in_write_value = '0;
    in_coord1 = '0; in_coord2 = '0; in_coord3 = '0; in_coord4 = '0;
    out_pop = 1'b0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    fail_count = 0; rx_hold_left = 0; idle_cycles = 0;
    tx_idle_pct = 0; rx_idle_pct = 0; spread = ONE;
    for (int a = 0; a < 4; a++) axis_size[a] = SIZE_RESET;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Define every breakpoint (k * 1.0) and every table entry that the axis
    // sizes can reach (address * 1.0), so no query reads an unwritten location.
    for (int a = 0; a < 4; a++)
      for (int k = 0; k < NPTS; k++)
        send_txn(mk(OP_BP_WRITE, a, k, 0, k * ONE, 0, 0, 0, 0, 1'b0, 0));
    for (int i = 0; i < TBL_USED; i++)
      send_txn(mk(OP_TB_WRITE, 0, 0, i, i * ONE, 0, 0, 0, 0, 1'b0, 0));

    // Directed part at reset sizes (2 points per axis): the table is linear,
    // value = 2*c1 + c2 + 4*c3 + 8*c4 inside the unit hypercube.
    directed = '{
      mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 0),
      mk(OP_QUERY, 0, 0, 0, 0, ONE, ONE, ONE, ONE, 1'b1, 15 * ONE),
      mk(OP_QUERY, 0, 0, 0, 0, ONE/2, ONE/2, ONE/2, ONE/2, 1'b1, 15 * ONE / 2),
      // below the first breakpoint clamps to zero fraction
      mk(OP_QUERY, 0, 0, 0, 0, MINV, MINV, MINV, MINV, 1'b1, 0),
      // at or above the last breakpoint clamps to one
      mk(OP_QUERY, 0, 0, 0, 0, MAXV, MAXV, MAXV, MAXV, 1'b1, 15 * ONE),
      mk(OP_QUERY, 0, 0, 0, 0, ONE, 0, 0, 0, 1'b1, 2 * ONE),
      mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, ONE, 1'b1, 8 * ONE),
      mk(OP_TB_WRITE, 0, 0, 0, MINV, 0, 0, 0, 0, 1'b0, 0),
      mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, MINV),
      mk(OP_TB_WRITE, 0, 0, 15, MAXV, 0, 0, 0, 0, 1'b0, 0),
      mk(OP_QUERY, 0, 0, 0, 0, ONE, ONE, ONE, ONE, 1'b1, MAXV),
      mk(OP_QUERY, 0, 0, 0, 0, 12345, -7, 65535, 40000, 1'b0, 0),
      // unused opcode: dropped, no result
      mk(OP_UNUSED, 3, 7, 4095, MAXV, MAXV, MINV, MAXV, MINV, 1'b0, 0),
      mk(OP_BP_WRITE, 3, 7, 0, MAXV, 0, 0, 0, 0, 1'b0, 0),
      mk(OP_TB_WRITE, 0, 0, 4095, MINV, 0, 0, 0, 0, 1'b0, 0),
      // flat interval on axis 1
      mk(OP_BP_WRITE, 0, 1, 0, 0, 0, 0, 0, 0, 1'b0, 0),
      mk(OP_QUERY, 0, 0, 0, 0, ONE/2, ONE/3, 0, 0, 1'b0, 0),
      mk(OP_QUERY, 0, 0, 0, 0, 0, ONE/3, ONE, 0, 1'b0, 0),
      // decreasing interval on axis 2
      mk(OP_BP_WRITE, 1, 1, 0, -ONE, 0, 0, 0, 0, 1'b0, 0),
      mk(OP_QUERY, 0, 0, 0, 0, ONE/4, -ONE/2, ONE/4, ONE/4, 1'b0, 0),
      mk(OP_BP_WRITE, 0, 1, 0, ONE, 0, 0, 0, 0, 1'b0, 0),
      mk(OP_BP_WRITE, 1, 1, 0, ONE, 0, 0, 0, 0, 1'b0, 0),
      mk(OP_QUERY, 0, 0, 0, 0, ONE/8, 3*ONE/8, 5*ONE/8, 7*ONE/8, 1'b0, 0)
    };
    foreach (directed[i]) send_txn(directed[i]);
    drain_core();

    // Random phases: new sizes and breakpoints each, idling per schedule.
    for (int p = 0; p < 12; p++) begin
      tx_idle_pct = (p < 4) ? 7 : (p < 8) ? 49 : 0;
      rx_idle_pct = (p < 4) ? 49 : (p < 8) ? 7 : 0;
      case (p)
        0: write_sizes(4'd2, 4'd2, 4'd2, 4'd2);
        1: write_sizes(4'd8, 4'd8, 4'd2, 4'd2);
        2: write_sizes(4'd0, 4'd1, 4'd15, 4'd9);
        default: random_sizes();
      endcase
      case (p % 4)
        0: spread = 256;
        1: spread = ONE;
        2: spread = 1 << 22;
        default: spread = (p == 7) ? 0 : 1;
      endcase
      for (int a = 0; a < 4; a++) load_axis(a);
      // long receiver hold-off: the core fills up and pushes back
      if (p == 1) rx_hold_left = 3000;
      for (int k = 0; k < 40; k++) begin
        // sender pause until every result has come
        if (p == 5 && k == 20) begin
          in_push <= 1'b0;
          while (interp_expected.size() != 0) @(posedge clk);
        end
        random_txn();
      end
      drain_core();
    end

    if (fail_count == 0)
      $display("quadrilinear_table_interp_core_tb OK");
    else
      $display("quadrilinear_table_interp_core_tb NOT OK");
    $finish;
  end

endmodule
